### hw/rtl/kfq_pkg.sv
// Shared types and constants of the keyed FIFO queue.
package kfq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned KeyW = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQUEUE = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_FIND    = 3'd3,
    CMD_REMOVE  = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_ROTATE = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic signed [KeyW-1:0] key;
    logic signed [KeyW-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    status_e                status;
    logic signed [KeyW-1:0] key_out;
    logic signed [KeyW-1:0] value_out;
  } rsp_t;

endpackage

### hw/rtl/kfq_if.sv
// Handshake interfaces of the command and result channels.
interface kfq_cmd_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             command;
  logic signed [31:0]     key_in;
  logic signed [31:0]     value_in;

  modport source (output valid, command, key_in, value_in, input ready);
  modport sink (input valid, command, key_in, value_in, output ready);
endinterface

interface kfq_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic signed [31:0]     key_out;
  logic signed [31:0]     value_out;

  modport source (output valid, status, key_out, value_out, input ready);
  modport sink (input valid, status, key_out, value_out, output ready);
endinterface

### hw/rtl/keyed_fifo_queue.sv
// Top level of the keyed FIFO queue: command decode, search sequencer and cell chain.
//
// Usage: commands arrive as beats on cmd_i (enqueue, dequeue, peek front,
// find by key, remove by key) and every command yields exactly one result
// beat on rsp_o with a status and, where an entry is returned, its key and
// value. Entries live in a chain of Depth cells, oldest at cell zero.
// Enqueue, dequeue, peek and commands that meet an empty queue push their
// result into the result buffer in the same cycle as the command beat.
// Find and remove rotate the whole chain past the head comparator one cell
// per cycle: after the command beat they step through every entry while
// cmd_i.ready is low, and the result is pushed into the result buffer
// during the last step. Remove drops the oldest match during that rotation,
// so the remaining entries keep their order.
// Reset empties the queue and the result buffer.
// Results pass through a two-beat buffer, so one command is still taken
// while a result waits; when both buffer places are full, cmd_i.ready stays
// low until the receiver takes a beat.
module keyed_fifo_queue #(
  parameter int unsigned Depth = kfq_pkg::DefaultDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kfq_cmd_if.sink   cmd_i,
  kfq_rsp_if.source rsp_o
);
  import kfq_pkg::*;

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        steps_q, steps_d;
  logic                   found_q, found_d;
  logic                   rm_q, rm_d;
  logic signed [KeyW-1:0] srch_key_q, srch_key_d;
  logic signed [KeyW-1:0] hit_key_q, hit_key_d;
  logic signed [KeyW-1:0] hit_val_q, hit_val_d;

  logic [Depth-1:0]       occ;
  logic signed [KeyW-1:0] cell_key [Depth];
  logic signed [KeyW-1:0] cell_val [Depth];
  cell_ctl_t              ctl;
  logic                   cmd_fire;
  logic                   in_ready;
  logic                   buf_room;
  logic                   res_push;
  rsp_t                   res;
  logic                   is_search;
  logic                   hit;

  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign in_ready    = (state_q == ST_IDLE) && buf_room;
  assign cmd_i.ready = in_ready;
  assign is_search   = (cmd_e'(cmd_i.command) == CMD_FIND) ||
                       (cmd_e'(cmd_i.command) == CMD_REMOVE);
  assign hit         = !found_q && (cell_key[0] == srch_key_q);

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                   prev_occ;
    logic                   next_occ;
    logic signed [KeyW-1:0] next_key;
    logic signed [KeyW-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end

    if (i == Depth - 1) begin : g_last
      assign next_occ = 1'b0;
      assign next_key = '0;
      assign next_val = '0;
    end else begin : g_inner
      assign next_occ = occ[i+1];
      assign next_key = cell_key[i+1];
      assign next_val = cell_val[i+1];
    end

    kfq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .prev_occ_i  (prev_occ),
      .next_occ_i  (next_occ),
      .next_key_i  (next_key),
      .next_value_i(next_val),
      .occ_o       (occ[i]),
      .key_o       (cell_key[i]),
      .value_o     (cell_val[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire && is_search && (count_q != '0)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (steps_q == CntOne) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.key       = cell_key[0];
    ctl.value     = cell_val[0];
    res_push      = 1'b0;
    res.status    = STAT_OK;
    res.key_out   = '0;
    res.value_out = '0;
    count_d       = count_q;
    steps_d       = steps_q;
    found_d       = found_q;
    rm_d          = rm_q;
    srch_key_d    = srch_key_q;
    hit_key_d     = hit_key_q;
    hit_val_d     = hit_val_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          res_push = 1'b1;
          case (cmd_e'(cmd_i.command))
            CMD_ENQUEUE: begin
              if (count_q == CntFull) begin
                res.status = STAT_FULL;
              end else begin
                ctl.op    = OP_PUSH;
                ctl.key   = cmd_i.key_in;
                ctl.value = cmd_i.value_in;
                count_d   = count_q + CntOne;
              end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
              if (count_q == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                res.key_out   = cell_key[0];
                res.value_out = cell_val[0];
                if (cmd_e'(cmd_i.command) == CMD_DEQUEUE) begin
                  ctl.op  = OP_POP;
                  count_d = count_q - CntOne;
                end
              end
            end
            CMD_FIND, CMD_REMOVE: begin
              if (count_q == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                res_push   = 1'b0;
                steps_d    = count_q;
                found_d    = 1'b0;
                rm_d       = (cmd_e'(cmd_i.command) == CMD_REMOVE);
                srch_key_d = cmd_i.key_in;
                hit_key_d  = '0;
                hit_val_d  = '0;
              end
            end
            default: begin
              res.status = STAT_OK;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        steps_d = steps_q - CntOne;
        if (hit) begin
          found_d   = 1'b1;
          hit_key_d = cell_key[0];
          hit_val_d = cell_val[0];
        end
        if (hit && rm_q) begin
          ctl.op  = OP_POP;
          count_d = count_q - CntOne;
        end else begin
          ctl.op = OP_ROTATE;
        end
        if (steps_q == CntOne) begin
          res_push      = 1'b1;
          res.status    = (found_q || hit) ? STAT_OK : STAT_NOT_FOUND;
          res.key_out   = hit ? cell_key[0] : hit_key_q;
          res.value_out = hit ? cell_val[0] : hit_val_q;
        end
      end
      default: begin
        ctl.op = OP_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      steps_q <= '0;
      found_q <= 1'b0;
      rm_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      steps_q <= steps_d;
      found_q <= found_d;
      rm_q    <= rm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srch_key_q <= srch_key_d;
    hit_key_q  <= hit_key_d;
    hit_val_q  <= hit_val_d;
  end

  kfq_out_buf u_out_buf (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(res_push),
    .data_i(res),
    .room_o(buf_room),
    .rsp_o (rsp_o)
  );

`ifndef ASSERT_OFF
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ) == int'(count_q))
    else $error("Fill count disagrees with occupied cells.");

  a_head_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == !occ[0])
    else $error("Head cell occupancy disagrees with empty state.");

  a_search_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> ((steps_q != '0) && (steps_q <= count_q)))
    else $error("Search step count out of range.");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && (cmd_e'(cmd_i.command) == CMD_ENQUEUE) && (count_q == CntFull))
      |=> $stable(count_q))
    else $error("Enqueue into a full queue changed the fill count.");

  a_no_push_without_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && (state_q == ST_IDLE)) |-> buf_room)
    else $error("Result beat pushed into a full buffer.");
`endif

endmodule

### hw/rtl/kfq_cell.sv
// One storage cell of the queue chain, holding a single key-value pair.
module kfq_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kfq_pkg::cell_ctl_t              ctl_i,
  input  logic                            prev_occ_i,
  input  logic                            next_occ_i,
  input  logic signed [kfq_pkg::KeyW-1:0] next_key_i,
  input  logic signed [kfq_pkg::KeyW-1:0] next_value_i,
  output logic                            occ_o,
  output logic signed [kfq_pkg::KeyW-1:0] key_o,
  output logic signed [kfq_pkg::KeyW-1:0] value_o
);
  import kfq_pkg::*;

  logic                   occ_q, occ_d;
  logic signed [KeyW-1:0] key_q, key_d;
  logic signed [KeyW-1:0] value_q, value_d;

  always_comb begin
    occ_d   = occ_q;
    key_d   = key_q;
    value_d = value_q;
    case (ctl_i.op)
      OP_PUSH: begin
        if (!occ_q && prev_occ_i) begin
          occ_d   = 1'b1;
          key_d   = ctl_i.key;
          value_d = ctl_i.value;
        end
      end
      OP_POP: begin
        occ_d   = next_occ_i;
        key_d   = next_key_i;
        value_d = next_value_i;
      end
      OP_ROTATE: begin
        if (occ_q && next_occ_i) begin
          key_d   = next_key_i;
          value_d = next_value_i;
        end else if (occ_q) begin
          key_d   = ctl_i.key;
          value_d = ctl_i.value;
        end
      end
      default: begin
        occ_d = occ_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign occ_o   = occ_q;
  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

### hw/rtl/kfq_out_buf.sv
// Two-beat result buffer that decouples the queue from the result receiver.
module kfq_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  kfq_pkg::rsp_t   data_i,
  output logic            room_o,
  kfq_rsp_if.source       rsp_o
);
  import kfq_pkg::*;

  rsp_t       slot0_q, slot0_d;
  rsp_t       slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop = rsp_o.valid && rsp_o.ready;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    cnt_d   = cnt_q;
    case ({push_i, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          slot0_d = data_i;
        end else begin
          slot1_d = data_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        slot0_d = slot1_q;
        cnt_d   = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          slot0_d = data_i;
        end else begin
          slot0_d = slot1_q;
          slot1_d = data_i;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign room_o          = (cnt_q != 2'd2);
  assign rsp_o.valid     = (cnt_q != 2'd0);
  assign rsp_o.status    = slot0_q.status;
  assign rsp_o.key_out   = slot0_q.key_out;
  assign rsp_o.value_out = slot0_q.value_out;

endmodule

### test/tb.sv
// Self-checking testbench of the keyed FIFO queue with a shadow queue scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kfq_pkg::*;

  localparam int unsigned QueueDepth = DefaultDepth;
  localparam logic signed [31:0] KeyMin = 32'h8000_0000;
  localparam logic signed [31:0] KeyMax = 32'h7fff_ffff;
  localparam int PhaseItems = 475;

  class queue_shadow;
    logic signed [31:0] shadow_keys[$];
    logic signed [31:0] shadow_vals[$];
    rsp_t expected_rsp[$];
    int failures = 0;

    function int fill_level();
      return shadow_keys.size();
    endfunction

    function logic signed [31:0] key_at(int idx);
      return shadow_keys[idx];
    endfunction

    function int outstanding();
      return expected_rsp.size();
    endfunction

    function void report(string msg);
      if (failures < 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
      failures++;
    endfunction

    function void apply_command(cmd_e cmd, logic signed [31:0] key, logic signed [31:0] value);
      rsp_t rsp;
      int hit;
      rsp.status = STAT_OK;
      rsp.key_out = '0;
      rsp.value_out = '0;
      hit = -1;
      case (cmd)
        CMD_ENQUEUE: begin
          if (shadow_keys.size() >= QueueDepth) begin
            rsp.status = STAT_FULL;
          end else begin
            shadow_keys.push_back(key);
            shadow_vals.push_back(value);
          end
        end
        CMD_DEQUEUE, CMD_PEEK: begin
          if (shadow_keys.size() == 0) begin
            rsp.status = STAT_EMPTY;
          end else begin
            rsp.key_out = shadow_keys[0];
            rsp.value_out = shadow_vals[0];
            if (cmd == CMD_DEQUEUE) begin
              shadow_keys.delete(0);
              shadow_vals.delete(0);
            end
          end
        end
        CMD_FIND, CMD_REMOVE: begin
          if (shadow_keys.size() == 0) begin
            rsp.status = STAT_EMPTY;
          end else begin
            rsp.status = STAT_NOT_FOUND;
            foreach (shadow_keys[i]) begin
              if (hit < 0 && shadow_keys[i] == key) hit = i;
            end
            if (hit >= 0) begin
              rsp.status = STAT_OK;
              rsp.key_out = shadow_keys[hit];
              rsp.value_out = shadow_vals[hit];
              if (cmd == CMD_REMOVE) begin
                shadow_keys.delete(hit);
                shadow_vals.delete(hit);
              end
            end
          end
        end
        default: ;
      endcase
      expected_rsp.push_back(rsp);
    endfunction

    function void check_response(logic [1:0] status, logic signed [31:0] key,
                                 logic signed [31:0] value);
      rsp_t exp_rsp;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected result beat: status %0d key %h value %h",
                         status, key, value));
        return;
      end
      exp_rsp = expected_rsp.pop_front();
      if (status !== exp_rsp.status || key !== exp_rsp.key_out
          || value !== exp_rsp.value_out) begin
        report($sformatf("result mismatch: status %0d/%0d key %h/%h value %h/%h (exp/act)",
                         exp_rsp.status, status, exp_rsp.key_out, key,
                         exp_rsp.value_out, value));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  queue_shadow board = new();

  kfq_cmd_if cmd_bus ();
  kfq_rsp_if rsp_bus ();

  keyed_fifo_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [31:0] random_word(int pool_pct);
    logic signed [31:0] word;
    int pick;
    pick = $urandom_range(99);
    if (pick < pool_pct) begin
      word = $urandom_range(7);
    end else if (pick < pool_pct + 10) begin
      case ($urandom_range(3))
        0: word = KeyMin;
        1: word = KeyMax;
        2: word = '0;
        default: word = '1;
      endcase
    end else begin
      word = $urandom;
    end
    return word;
  endfunction

  task automatic send_command(input cmd_e cmd, input logic signed [31:0] key,
                              input logic signed [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.command <= cmd;
    cmd_bus.key_in <= key;
    cmd_bus.value_in <= value;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    board.apply_command(cmd, key, value);
  endtask

  task automatic send_random(int enq_pct);
    cmd_e cmd;
    logic signed [31:0] key;
    if ($urandom_range(99) < enq_pct) begin
      cmd = CMD_ENQUEUE;
    end else begin
      case ($urandom_range(3))
        0: cmd = CMD_DEQUEUE;
        1: cmd = CMD_PEEK;
        2: cmd = CMD_FIND;
        default: cmd = CMD_REMOVE;
      endcase
    end
    if ((cmd == CMD_FIND || cmd == CMD_REMOVE) && board.fill_level() > 0
        && $urandom_range(99) < 65) begin
      key = board.key_at($urandom_range(board.fill_level() - 1));
    end else begin
      key = random_word(40);
    end
    send_command(cmd, key, random_word(5));
  endtask

  task automatic wait_drained();
    cmd_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    cmd_bus.valid <= 1'b0;
    cmd_bus.command <= CMD_ENQUEUE;
    cmd_bus.key_in <= '0;
    cmd_bus.value_in <= '0;
    rsp_bus.ready <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        board.check_response(rsp_bus.status, rsp_bus.key_out, rsp_bus.value_out);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int n;
    int ph;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Every command on an empty queue, then fill to capacity and overflow.
    send_command(CMD_DEQUEUE, 32'sd0, 32'sd0);
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    send_command(CMD_FIND, 32'sd5, 32'sd0);
    send_command(CMD_REMOVE, 32'sd5, 32'sd0);
    send_command(CMD_ENQUEUE, KeyMin, KeyMax);
    send_command(CMD_ENQUEUE, KeyMax, KeyMin);
    send_command(CMD_ENQUEUE, '1, '0);
    send_command(CMD_ENQUEUE, KeyMin, '1);
    for (n = 4; n < QueueDepth; n++) begin
      send_command(CMD_ENQUEUE, n, ~n);
    end
    send_command(CMD_ENQUEUE, 32'sd42, 32'sd42);
    send_command(CMD_PEEK, 32'sd0, 32'sd0);
    send_command(CMD_FIND, KeyMin, 32'sd0);
    send_command(CMD_FIND, 32'sd12345, 32'sd0);
    send_command(CMD_REMOVE, '1, 32'sd0);
    send_command(CMD_REMOVE, 32'sd12345, 32'sd0);
    send_command(CMD_DEQUEUE, 32'sd0, 32'sd0);
    wait_drained();

    // The queue level sweeps between empty and full as the enqueue share alternates.
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 14 : 0;
      for (n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == 100) hold_cycles = 80;
        if (ph == 1 && n == 200) wait_drained();
        send_random(((n / 48) % 2 == 0) ? 75 : 25);
      end
      wait_drained();
    end

    repeat (QueueDepth + 4) @(posedge clk_i);
    if (board.failures == 0 && board.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hw/rtl/kfq_pkg.sv
hw/rtl/kfq_if.sv
hw/rtl/kfq_cell.sv
hw/rtl/kfq_out_buf.sv
hw/rtl/keyed_fifo_queue.sv
test/tb.sv
